// ----- design/bulk_only_transport_host_sequencer_defines.svh -----
// Assertion macros used by the sequencer output queue.
`ifndef BULK_ONLY_TRANSPORT_HOST_SEQUENCER_DEFINES_SVH
`define BULK_ONLY_TRANSPORT_HOST_SEQUENCER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Check a condition at every clock edge out of reset.
`define BOTS_ASSERT(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// Check that a trigger is followed by a condition in the next cycle.
`define BOTS_ASSERT_NEXT(lbl, clk, rst_n, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("assertion failed");

`else

`define BOTS_ASSERT(lbl, clk, rst_n, cond)
`define BOTS_ASSERT_NEXT(lbl, clk, rst_n, trig, cond)

`endif

`endif

// ----- design/bots_pkg.sv -----
`default_nettype none

package bots_pkg;

    localparam int ENUM_STEPS  = 6;
    localparam int LIST_LEN    = 6;
    localparam int STEP_COUNT  = (ENUM_STEPS < LIST_LEN) ? ENUM_STEPS : LIST_LEN;
    localparam int OFIFO_DEPTH = 4;
    localparam int OFIFO_AW    = $clog2(OFIFO_DEPTH);
    localparam int OFIFO_CW    = $clog2(OFIFO_DEPTH + 1);

    typedef enum logic [2:0] {
        CMD_ATTACH  = 3'd0,
        CMD_POLL    = 3'd1,
        CMD_DONE    = 3'd2,
        CMD_READ10  = 3'd3,
        CMD_WRITE10 = 3'd4,
        CMD_REMOVE  = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RETRY = 2'd1,
        ST_SIZE  = 2'd2,
        ST_FATAL = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        ACT_NONE   = 4'd0,
        ACT_MAXLUN = 4'd1,
        ACT_CBW    = 4'd2,
        ACT_DIN    = 4'd3,
        ACT_DOUT   = 4'd4,
        ACT_CSW    = 4'd5,
        ACT_DONE   = 4'd6,
        ACT_CONN   = 4'd7,
        ACT_ERR    = 4'd8
    } t_action;

    typedef enum logic [3:0] {
        DP_INACTIVE    = 4'd0,
        DP_IDLE        = 4'd1,
        DP_MAXLUN_REQ  = 4'd2,
        DP_MAXLUN_WAIT = 4'd3,
        DP_ENUM_REQ    = 4'd4,
        DP_ENUM_WAIT   = 4'd5,
        DP_READ_WAIT   = 4'd6,
        DP_WRITE_WAIT  = 4'd7
    } t_dev_phase;

    typedef enum logic [3:0] {
        TP_IDLE = 4'd0,
        TP_CBW  = 4'd1,
        TP_DIN  = 4'd2,
        TP_DOUT = 4'd3,
        TP_CSW  = 4'd4
    } t_xfer_phase;

    localparam logic [7:0] OP_TEST_UNIT_READY = 8'h00;
    localparam logic [7:0] OP_READ_CAPACITY   = 8'h25;
    localparam logic [7:0] OP_READ10          = 8'h28;
    localparam logic [7:0] OP_WRITE10         = 8'h2A;
    localparam logic [7:0] OP_INQUIRY         = 8'h12;
    localparam logic [7:0] OP_MODE_SENSE6     = 8'h1A;
    localparam logic [7:0] OP_REQUEST_SENSE   = 8'h03;
    localparam logic [7:0] REQ_MAX_LUN        = 8'd254;
    localparam logic [4:0] CDB_LEN_6          = 5'd6;
    localparam logic [4:0] CDB_LEN_10         = 5'd10;
    localparam logic [4:0] CDB_LEN_NONE       = 5'd0;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [1:0]  status;
        logic [31:0] start_block;
        logic [15:0] blocks;
        logic [31:0] cap_blocks;
        logic [31:0] cap_block_bytes;
    } t_item;

    typedef struct packed {
        t_action     action;
        logic [7:0]  opcode;
        logic [4:0]  cdb_length;
        logic        direction_in;
        logic [31:0] transfer_length;
        logic [31:0] out_block;
        logic [15:0] out_blocks;
        logic        last;
    } t_result;

    typedef struct packed {
        logic [1:0] n;
        t_result    r0;
        t_result    r1;
    } t_emit;

    typedef struct packed {
        t_dev_phase  dev;
        t_xfer_phase xfer;
        logic [2:0]  enum_index;
        logic [7:0]  cur_opcode;
        logic [31:0] cur_length;
        logic        cur_dir_in;
        logic [31:0] cur_block;
        logic [15:0] cur_count;
        logic [31:0] block_bytes;
        logic [31:0] block_total;
    } t_state;

    localparam t_state STATE_RESET = '{
        dev:         DP_INACTIVE,
        xfer:        TP_IDLE,
        enum_index:  3'd0,
        cur_opcode:  8'd0,
        cur_length:  32'd0,
        cur_dir_in:  1'b0,
        cur_block:   32'd0,
        cur_count:   16'd0,
        block_bytes: 32'd0,
        block_total: 32'd0
    };

    function automatic logic [7:0] list_op(input logic [2:0] idx);
        logic [7:0] op;
        case (idx)
            3'd1:    op = OP_READ_CAPACITY;
            3'd3:    op = OP_INQUIRY;
            3'd4:    op = OP_MODE_SENSE6;
            3'd5:    op = OP_REQUEST_SENSE;
            default: op = OP_TEST_UNIT_READY;
        endcase
        return op;
    endfunction

    function automatic logic [31:0] list_len(input logic [2:0] idx);
        logic [31:0] len;
        case (idx)
            3'd0:    len = 32'd1;
            3'd1:    len = 32'd8;
            3'd3:    len = 32'd96;
            3'd4:    len = 32'd10;
            3'd5:    len = 32'd8;
            default: len = 32'd0;
        endcase
        return len;
    endfunction

    function automatic logic [4:0] cdb_len_of(input logic [7:0] op);
        return (op == OP_READ_CAPACITY || op == OP_READ10 || op == OP_WRITE10)
            ? CDB_LEN_10 : CDB_LEN_6;
    endfunction

    function automatic t_result make_result(input t_action a, input logic [7:0] op,
                                            input logic [4:0] clen, input logic dir,
                                            input logic [31:0] len, input logic [31:0] blk,
                                            input logic [15:0] cnt);
        t_result r;
        r.action          = a;
        r.opcode          = op;
        r.cdb_length      = clen;
        r.direction_in    = dir;
        r.transfer_length = len;
        r.out_block       = blk;
        r.out_blocks      = cnt;
        r.last            = 1'b0;
        return r;
    endfunction

    function automatic t_result bare(input t_action a);
        return make_result(a, 8'd0, CDB_LEN_NONE, 1'b0, 32'd0, 32'd0, 16'd0);
    endfunction

    function automatic t_result xact(input t_action a, input t_state s);
        return make_result(a, s.cur_opcode, cdb_len_of(s.cur_opcode), s.cur_dir_in,
                           s.cur_length, s.cur_block, s.cur_count);
    endfunction

endpackage

`default_nettype wire

// ----- design/bots_step.sv -----
`default_nettype none

module bots_step (
    input  bots_pkg::t_item  i_item,
    input  bots_pkg::t_state i_state,
    output bots_pkg::t_state o_state,
    output bots_pkg::t_emit  o_emit
);
    import bots_pkg::*;

    logic        w_idx_bad;
    logic        w_adv_done;
    logic        w_is_read;
    logic [47:0] w_prod;
    t_state      nxt;
    t_emit       emit;

    assign w_idx_bad  = (i_state.enum_index == 3'd0) || (int'(i_state.enum_index) >= LIST_LEN);
    assign w_adv_done = (int'(i_state.enum_index) + 1) >= STEP_COUNT;
    assign w_is_read  = (i_item.cmd == CMD_READ10);
    // byte count wraps to 32 bits
    assign w_prod     = 48'(i_item.blocks) * 48'(i_state.block_bytes);

    // next state
    always_comb begin
        nxt = i_state;
        unique case (i_item.cmd)
            CMD_ATTACH: begin
                if (i_state.dev == DP_INACTIVE) begin
                    nxt.xfer       = TP_IDLE;
                    nxt.enum_index = 3'd0;
                    nxt.dev        = DP_MAXLUN_REQ;
                end
            end
            CMD_POLL: begin
                if (i_state.xfer == TP_IDLE) begin
                    if (i_state.dev == DP_MAXLUN_REQ) begin
                        nxt.dev = DP_MAXLUN_WAIT;
                    end else if (i_state.dev == DP_ENUM_REQ) begin
                        if (w_idx_bad) begin
                            nxt.dev = DP_IDLE;
                        end else begin
                            nxt.cur_opcode = list_op(i_state.enum_index);
                            nxt.cur_length = list_len(i_state.enum_index);
                            nxt.cur_dir_in = 1'b1;
                            nxt.cur_block  = 32'd0;
                            nxt.cur_count  = 16'd0;
                            nxt.dev        = DP_ENUM_WAIT;
                            nxt.xfer       = TP_CBW;
                        end
                    end
                end
            end
            CMD_DONE: begin
                unique case (i_state.xfer)
                    TP_IDLE: begin
                        if (i_state.dev == DP_MAXLUN_WAIT) begin
                            if (i_item.status == ST_OK) begin
                                if (w_adv_done) begin
                                    nxt.dev = DP_IDLE;
                                end else begin
                                    nxt.enum_index = i_state.enum_index + 3'd1;
                                    nxt.dev        = DP_ENUM_REQ;
                                end
                            end else begin
                                nxt.dev = DP_INACTIVE;
                            end
                        end
                    end
                    TP_CBW: begin
                        if (i_item.status == ST_OK) begin
                            if (i_state.cur_opcode == OP_WRITE10) begin
                                nxt.xfer = TP_DOUT;
                            end else if (i_state.cur_opcode == OP_TEST_UNIT_READY) begin
                                nxt.xfer = TP_CSW;
                            end else begin
                                nxt.xfer = TP_DIN;
                            end
                        end
                    end
                    TP_DIN: begin
                        if (i_item.status == ST_OK) begin
                            if (i_state.cur_opcode == OP_READ_CAPACITY) begin
                                nxt.block_total = i_item.cap_blocks;
                                nxt.block_bytes = i_item.cap_block_bytes;
                            end
                            nxt.xfer = TP_CSW;
                        end
                    end
                    TP_DOUT: begin
                        if (i_item.status == ST_OK) begin
                            nxt.xfer = TP_CSW;
                        end
                    end
                    TP_CSW: begin
                        if (i_item.status == ST_OK) begin
                            nxt.xfer = TP_IDLE;
                            if (i_state.dev == DP_ENUM_WAIT) begin
                                if (w_adv_done) begin
                                    nxt.dev = DP_IDLE;
                                end else begin
                                    nxt.enum_index = i_state.enum_index + 3'd1;
                                    nxt.dev        = DP_ENUM_REQ;
                                end
                            end else if (i_state.dev == DP_READ_WAIT ||
                                         i_state.dev == DP_WRITE_WAIT) begin
                                nxt.dev = DP_IDLE;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            CMD_READ10, CMD_WRITE10: begin
                nxt.cur_opcode = w_is_read ? OP_READ10 : OP_WRITE10;
                nxt.cur_dir_in = w_is_read;
                nxt.cur_block  = i_item.start_block;
                nxt.cur_count  = i_item.blocks;
                nxt.cur_length = w_prod[31:0];
                nxt.dev        = w_is_read ? DP_READ_WAIT : DP_WRITE_WAIT;
                nxt.xfer       = TP_CBW;
            end
            CMD_REMOVE: begin
                nxt.dev  = DP_INACTIVE;
                nxt.xfer = TP_IDLE;
            end
            default: begin
            end
        endcase
    end

    // results; transaction beats carry the updated transaction fields
    always_comb begin
        emit.n  = 2'd0;
        emit.r0 = bare(ACT_NONE);
        emit.r1 = bare(ACT_CONN);
        unique case (i_item.cmd)
            CMD_POLL: begin
                if (i_state.xfer == TP_IDLE) begin
                    if (i_state.dev == DP_MAXLUN_REQ) begin
                        emit.n  = 2'd2;
                        emit.r0 = make_result(ACT_MAXLUN, REQ_MAX_LUN, CDB_LEN_NONE, 1'b1,
                                              32'd1, 32'd0, 16'd0);
                    end else if (i_state.dev == DP_ENUM_REQ && !w_idx_bad) begin
                        emit.n  = 2'd1;
                        emit.r0 = xact(ACT_CBW, nxt);
                    end
                end
            end
            CMD_DONE: begin
                emit.n  = 2'd1;
                emit.r0 = bare(ACT_ERR);
                unique case (i_state.xfer)
                    TP_IDLE: begin
                        if (i_state.dev == DP_MAXLUN_WAIT && i_item.status == ST_OK) begin
                            emit.r0 = bare(ACT_CONN);
                        end
                    end
                    TP_CBW: begin
                        if (i_item.status == ST_OK) begin
                            if (i_state.cur_opcode == OP_WRITE10) begin
                                emit.r0 = xact(ACT_DOUT, nxt);
                            end else if (i_state.cur_opcode == OP_TEST_UNIT_READY) begin
                                emit.r0 = bare(ACT_CSW);
                            end else begin
                                emit.r0 = xact(ACT_DIN, nxt);
                            end
                        end else if (i_item.status == ST_RETRY) begin
                            emit.r0 = xact(ACT_CBW, nxt);
                        end
                    end
                    TP_DIN: begin
                        if (i_item.status == ST_OK) begin
                            emit.r0 = bare(ACT_CSW);
                        end
                    end
                    TP_DOUT: begin
                        if (i_item.status == ST_OK) begin
                            emit.r0 = bare(ACT_CSW);
                        end else if (i_item.status == ST_RETRY) begin
                            emit.r0 = xact(ACT_DOUT, nxt);
                        end
                    end
                    TP_CSW: begin
                        if (i_item.status == ST_OK) begin
                            if (i_state.dev == DP_READ_WAIT || i_state.dev == DP_WRITE_WAIT) begin
                                emit.r0 = bare(ACT_DONE);
                            end else begin
                                emit.n = 2'd0;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            CMD_READ10, CMD_WRITE10: begin
                emit.n  = 2'd1;
                emit.r0 = xact(ACT_CBW, nxt);
            end
            default: begin
            end
        endcase
        emit.r0.last = (emit.n == 2'd1);
        emit.r1.last = 1'b1;
    end

    assign o_state = nxt;
    assign o_emit  = emit;

endmodule

`default_nettype wire

// ----- design/bots_ofifo.sv -----
`default_nettype none
`include "bulk_only_transport_host_sequencer_defines.svh"

module bots_ofifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bots_pkg::t_emit   i_emit,
    input  logic              i_pop,
    output bots_pkg::t_result o_head,
    output logic              o_not_empty,
    output logic              o_room2
);
    import bots_pkg::*;

    t_result               r_mem [OFIFO_DEPTH];
    logic [OFIFO_AW-1:0]   r_wr_ptr;
    logic [OFIFO_AW-1:0]   r_rd_ptr;
    logic [OFIFO_CW-1:0]   r_count;
    logic [OFIFO_AW-1:0]   n_wr_ptr;
    logic [OFIFO_CW-1:0]   n_count;
    logic [OFIFO_AW-1:0]   w_wr_ptr1;

    assign w_wr_ptr1   = r_wr_ptr + OFIFO_AW'(1);
    assign n_wr_ptr    = r_wr_ptr + OFIFO_AW'(i_emit.n);
    assign n_count     = r_count + OFIFO_CW'(i_emit.n) - OFIFO_CW'(i_pop);
    assign o_head      = r_mem[r_rd_ptr];
    assign o_not_empty = (r_count != '0);
    assign o_room2     = (int'(r_count) <= OFIFO_DEPTH - 2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_count  <= n_count;
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + OFIFO_AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_emit.n != 2'd0) begin
            r_mem[r_wr_ptr] <= i_emit.r0;
        end
        if (i_emit.n == 2'd2) begin
            r_mem[w_wr_ptr1] <= i_emit.r1;
        end
    end

    `BOTS_ASSERT(a_count_bound, i_clk, i_rst_n, int'(r_count) <= OFIFO_DEPTH)
    `BOTS_ASSERT(a_push_needs_room, i_clk, i_rst_n, (i_emit.n == 2'd0) || o_room2)
    `BOTS_ASSERT(a_no_pop_empty, i_clk, i_rst_n, !i_pop || o_not_empty)
    `BOTS_ASSERT_NEXT(a_pop_drains, i_clk, i_rst_n, i_pop && (i_emit.n == 2'd0), r_count == $past(r_count) - OFIFO_CW'(1))

endmodule

`default_nettype wire

// ----- design/bulk_only_transport_host_sequencer.sv -----
// An accepted beat is registered in the input register and processed, and its results
// queued, once the output queue has room for two beats. Throughput: one event per cycle
// while the queue has that room; a max-LUN poll yields two result beats, which the
// four-entry output queue absorbs while the next event is already taken.
// Reset: synchronous, active low; device inactive, transaction idle, queue empty.
`default_nettype none

module bulk_only_transport_host_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_cmd,
    input  logic [1:0]  i_status,
    input  logic [31:0] i_start_block,
    input  logic [15:0] i_blocks,
    input  logic [31:0] i_cap_blocks,
    input  logic [31:0] i_cap_block_bytes,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [3:0]  o_action,
    output logic [7:0]  o_opcode,
    output logic [4:0]  o_cdb_length,
    output logic        o_direction_in,
    output logic [31:0] o_transfer_length,
    output logic [31:0] o_out_block,
    output logic [15:0] o_out_blocks,
    output logic        o_last
);
    import bots_pkg::*;

    // input register
    logic    r_in_valid;
    t_item   r_item;

    // sequencer state
    t_state  r_state;
    t_state  n_state;

    t_emit   w_emit_raw;
    t_emit   w_emit;
    t_result w_head;
    logic    w_not_empty;
    logic    w_room2;
    logic    w_fire;
    logic    w_accept;
    logic    w_pop;

    // Process the held event only when the queue can take both possible result beats.
    assign w_fire   = r_in_valid && w_room2;
    // Take a new beat when the input register is empty or drains this cycle.
    assign o_ready  = !r_in_valid || w_fire;
    assign w_accept = i_valid && o_ready;
    assign w_pop    = w_not_empty && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    // Hold the payload until the event is processed.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item.cmd             <= i_cmd;
            r_item.status          <= i_status;
            r_item.start_block     <= i_start_block;
            r_item.blocks          <= i_blocks;
            r_item.cap_blocks      <= i_cap_blocks;
            r_item.cap_block_bytes <= i_cap_block_bytes;
        end
    end

    bots_step u_step (
        .i_item  (r_item),
        .i_state (r_state),
        .o_state (n_state),
        .o_emit  (w_emit_raw)
    );

    // Advance state only when the event fires.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
        end else if (w_fire) begin
            r_state <= n_state;
        end
    end

    // Drop the result beats unless the event fires this cycle.
    always_comb begin
        w_emit = w_emit_raw;
        if (!w_fire) begin
            w_emit.n = 2'd0;
        end
    end

    bots_ofifo u_ofifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_emit      (w_emit),
        .i_pop       (w_pop),
        .o_head      (w_head),
        .o_not_empty (w_not_empty),
        .o_room2     (w_room2)
    );

    assign o_valid           = w_not_empty;
    assign o_action          = w_head.action;
    assign o_opcode          = w_head.opcode;
    assign o_cdb_length      = w_head.cdb_length;
    assign o_direction_in    = w_head.direction_in;
    assign o_transfer_length = w_head.transfer_length;
    assign o_out_block       = w_head.out_block;
    assign o_out_blocks      = w_head.out_blocks;
    assign o_last            = w_head.last;

endmodule

`default_nettype wire
